@@ design/brfp_pkg.sv @@
// ----------------------------------------------------------------------------
// brfp_pkg: shared types and constants for the binary RPC frame parser
// Status codes, parser phases, magic bytes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package brfp_pkg;

   // result status codes
   localparam logic [2:0] ST_MORE      = 3'd0;
   localparam logic [2:0] ST_COMPLETE  = 3'd1;
   localparam logic [2:0] ST_IGNORED   = 3'd2;
   localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
   localparam logic [2:0] ST_HDR_BIG   = 3'd4;
   localparam logic [2:0] ST_DATA_BIG  = 3'd5;
   localparam logic [2:0] ST_INVALID   = 3'd6;
   localparam logic [2:0] ST_RESET     = 3'd7;

   // message type codes
   localparam logic [1:0] MT_UNKNOWN  = 2'd0;
   localparam logic [1:0] MT_REQUEST  = 2'd1;
   localparam logic [1:0] MT_RESPONSE = 2'd2;

   // request opcodes
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_RESET = 1'b1;

   // configuration register indexes
   localparam logic CSR_MAX_HEADER = 1'b0;
   localparam logic CSR_MAX_DATA   = 1'b1;

   localparam logic [31:0] MAX_HEADER_RESET = 32'd10485760;
   localparam logic [31:0] MAX_DATA_RESET   = 32'd104857600;

   localparam logic [7:0] MAGIC [3] = '{8'h42, 8'h69, 8'h6E};   // "Bin"

   localparam int FLAG_HEADER_BIT   = 6;
   localparam int FLAG_RESPONSE_BIT = 0;

   typedef enum logic [4:0] {
      PH_PRE  = 5'b00001,
      PH_HDR  = 5'b00010,
      PH_HLEN = 5'b00100,
      PH_DATA = 5'b01000,
      PH_DONE = 5'b10000
   } phase_type;

endpackage : brfp_pkg

`default_nettype wire

@@ design/binary_rpc_frame_parser.sv @@
// A result is registered: it appears in the cycle after its byte is accepted (result register).
// Throughput: one byte per cycle; the only loop is the parser state update. A result
//   stalled downstream holds off the next byte, which is taken in the cycle the pending
//   result transfers out (ready = !valid | rsp_ready).
// Reset: synchronous, active high; clears the frame state, drops any pending
//   result and restores both size limits to their defaults.
// ----------------------------------------------------------------------------
// binary_rpc_frame_parser: byte-serial delimiter for one binary RPC frame
// Checks the "Bin" magic, captures flag and length fields, tracks the header,
// the trailing length and the payload, and reports a status for every byte.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_rpc_frame_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte stream
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_byte_in,
   // per-byte result
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_byte_out,
   output logic [32:0]      rsp_byte_offset,
   output logic [1:0]       rsp_msg_type,
   output logic             rsp_has_header,
   output logic [32:0]      rsp_frame_length,
   // configuration
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [31:0] max_hdr_ff;
   logic [31:0] max_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_hdr_ff  <= brfp_pkg::MAX_HEADER_RESET;
         max_data_ff <= brfp_pkg::MAX_DATA_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            brfp_pkg::CSR_MAX_HEADER: max_hdr_ff  <= csr_data;
            brfp_pkg::CSR_MAX_DATA:   max_data_ff <= csr_data;
            default:                  max_hdr_ff  <= max_hdr_ff;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Frame state
   // ------------------------------------------------------------------------
   brfp_pkg::phase_type phase_ff, phase_in;
   logic [32:0] count_ff,    count_in;     // offset of the next byte
   logic [7:0]  flag_ff,     flag_in;
   logic [31:0] shift_ff,    shift_in;     // big-endian length assembly
   logic [31:0] hlen_ff,     hlen_in;      // header length
   logic [32:0] hdr_last_ff, hdr_last_in;  // offset of the last header byte
   logic [1:0]  lcnt_ff,     lcnt_in;      // byte index within trailing length
   logic [32:0] flen_ff,     flen_in;      // total frame length

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  status_ff,   status_in;
   logic [7:0]  byte_ff,     byte_in;
   logic [32:0] offset_ff,   offset_in;
   logic [1:0]  mtype_ff,    mtype_in;
   logic        hhdr_ff,     hhdr_in;
   logic [32:0] rflen_ff,    rflen_in;

   logic        take;
   logic [31:0] shift_next;
   logic [32:0] count_inc;
   logic [33:0] data_sum;     // trailing length + header length + 4, no wrap
   logic [32:0] frame_sum;    // data_sum + 8, valid when data_sum fits the limit

   // Take a new byte whenever the result slot is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   assign shift_next = {shift_ff[23:0], req_byte_in};
   assign count_inc  = count_ff + 33'd1;
   assign data_sum   = {2'b00, shift_next} + {2'b00, hlen_ff} + 34'd4;
   assign frame_sum  = {1'b0, shift_next} + {1'b0, hlen_ff} + 33'd12;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      flag_in     = flag_ff;
      shift_in    = shift_ff;
      hlen_in     = hlen_ff;
      hdr_last_in = hdr_last_ff;
      lcnt_in     = lcnt_ff;
      flen_in     = flen_ff;

      status_in = brfp_pkg::ST_MORE;
      byte_in   = 8'd0;
      offset_in = 33'd0;
      mtype_in  = brfp_pkg::MT_UNKNOWN;
      hhdr_in   = 1'b0;
      rflen_in  = 33'd0;

      if (req_opcode == brfp_pkg::OP_RESET) begin
         // start a new frame; limits are kept
         status_in   = brfp_pkg::ST_RESET;
         phase_in    = brfp_pkg::PH_PRE;
         count_in    = 33'd0;
         flag_in     = 8'd0;
         shift_in    = 32'd0;
         hlen_in     = 32'd0;
         hdr_last_in = 33'd0;
         lcnt_in     = 2'd0;
         flen_in     = 33'd0;
      end else if (phase_ff == brfp_pkg::PH_DONE) begin
         // latched: drop the byte
         status_in = brfp_pkg::ST_IGNORED;
      end else begin
         byte_in   = req_byte_in;
         offset_in = count_ff;

         case (phase_ff)
            brfp_pkg::PH_PRE: begin
               if (count_ff < 33'd3) begin
                  if (req_byte_in != brfp_pkg::MAGIC[count_ff[1:0]]) begin
                     status_in = brfp_pkg::ST_BAD_MAGIC;
                  end
               end else if (count_ff == 33'd3) begin
                  flag_in = req_byte_in;
               end else begin
                  shift_in = shift_next;
                  if (count_ff == 33'd7) begin
                     // first length complete: check against limits
                     if (flag_ff[brfp_pkg::FLAG_HEADER_BIT]) begin
                        hlen_in = shift_next;
                        if (shift_next > max_hdr_ff) begin
                           status_in = brfp_pkg::ST_HDR_BIG;
                        end
                     end else if (shift_next > max_data_ff) begin
                        status_in = brfp_pkg::ST_DATA_BIG;
                     end
                     if (status_in == brfp_pkg::ST_MORE && shift_next == 32'd0) begin
                        status_in = brfp_pkg::ST_INVALID;
                     end
                     if (status_in == brfp_pkg::ST_MORE) begin
                        if (flag_ff[brfp_pkg::FLAG_HEADER_BIT]) begin
                           phase_in    = brfp_pkg::PH_HDR;
                           shift_in    = 32'd0;
                           hdr_last_in = {1'b0, shift_next} + 33'd7;
                        end else begin
                           phase_in = brfp_pkg::PH_DATA;
                           flen_in  = {1'b0, shift_next} + 33'd8;
                           rflen_in = {1'b0, shift_next} + 33'd8;
                        end
                     end
                  end
               end
            end
            brfp_pkg::PH_HDR: begin
               if (count_ff == hdr_last_ff) begin
                  phase_in = brfp_pkg::PH_HLEN;
                  lcnt_in  = 2'd0;
               end
            end
            brfp_pkg::PH_HLEN: begin
               shift_in = shift_next;
               lcnt_in  = lcnt_ff + 2'd1;
               if (lcnt_ff == 2'd3) begin
                  if (data_sum > {2'b00, max_data_ff}) begin
                     status_in = brfp_pkg::ST_DATA_BIG;
                  end else begin
                     phase_in = brfp_pkg::PH_DATA;
                     flen_in  = frame_sum;
                     rflen_in = frame_sum;
                     // empty payload: this byte closes the frame
                     if (shift_next == 32'd0) begin
                        status_in = brfp_pkg::ST_COMPLETE;
                     end
                  end
               end
            end
            brfp_pkg::PH_DATA: begin
               rflen_in = flen_ff;
               if (count_inc == flen_ff) begin
                  status_in = brfp_pkg::ST_COMPLETE;
               end
            end
            default: begin
               status_in = brfp_pkg::ST_INVALID;
            end
         endcase

         if (count_ff >= 33'd7) begin
            mtype_in = flag_ff[brfp_pkg::FLAG_RESPONSE_BIT] ?
                       brfp_pkg::MT_RESPONSE : brfp_pkg::MT_REQUEST;
            hhdr_in  = flag_ff[brfp_pkg::FLAG_HEADER_BIT];
         end
         // errors report no frame length
         if (status_in >= brfp_pkg::ST_BAD_MAGIC) begin
            rflen_in = 33'd0;
         end
         // completion and errors latch until a reset item
         if (status_in != brfp_pkg::ST_MORE) begin
            phase_in = brfp_pkg::PH_DONE;
         end
         count_in = count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= brfp_pkg::PH_PRE;
         count_ff    <= 33'd0;
         flag_ff     <= 8'd0;
         shift_ff    <= 32'd0;
         hlen_ff     <= 32'd0;
         hdr_last_ff <= 33'd0;
         lcnt_ff     <= 2'd0;
         flen_ff     <= 33'd0;
      end else if (take) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         flag_ff     <= flag_in;
         shift_ff    <= shift_in;
         hlen_ff     <= hlen_in;
         hdr_last_ff <= hdr_last_in;
         lcnt_ff     <= lcnt_in;
         flen_ff     <= flen_in;
      end
   end

   // Result valid: set on a transfer in, clear when taken with nothing behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload: no reset needed, qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= status_in;
         byte_ff   <= byte_in;
         offset_ff <= offset_in;
         mtype_ff  <= mtype_in;
         hhdr_ff   <= hhdr_in;
         rflen_ff  <= rflen_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_byte_out     = byte_ff;
   assign rsp_byte_offset  = offset_ff;
   assign rsp_msg_type     = mtype_ff;
   assign rsp_has_header   = hhdr_ff;
   assign rsp_frame_length = rflen_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_reset_item: assert property (@(posedge clock) disable iff (reset)
      (take && req_opcode == brfp_pkg::OP_RESET) |=>
         (rsp_valid && rsp_status == brfp_pkg::ST_RESET && phase_ff == brfp_pkg::PH_PRE))
      else $error("reset item did not restart the frame");

   a_latch: assert property (@(posedge clock) disable iff (reset)
      (take && req_opcode == brfp_pkg::OP_BYTE && status_in != brfp_pkg::ST_MORE) |=>
         (phase_ff == brfp_pkg::PH_DONE))
      else $error("final or error status did not latch the parser");

   a_complete_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == brfp_pkg::ST_COMPLETE) |->
         (rsp_frame_length == rsp_byte_offset + 33'd1))
      else $error("completion reported away from the last frame byte");

   a_error_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status >= brfp_pkg::ST_BAD_MAGIC &&
       rsp_status != brfp_pkg::ST_RESET) |-> (rsp_frame_length == 33'd0))
      else $error("error result carries a frame length");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (!$changed(status_ff) && !$changed(offset_ff)))
      else $error("pending result overwritten");

endmodule : binary_rpc_frame_parser

`default_nettype wire
